// ===== rtl/rve_pkg.sv =====
// ----------------------------------------------------------------------------
// rve_pkg: shared definitions for the rv32i execute unit
// command codes, memory and status codes, field widths and the structs that
// pass between the execute logic and the top level
// ----------------------------------------------------------------------------
package rve_pkg;

    // register file geometry
    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int REG_FLD_W  = 5;

    localparam int XLEN       = 32;
    localparam int CMD_W      = 6;
    localparam int CFG_IDX_W  = 1;

    // packed stream widths (rounded up to whole bytes)
    localparam int S_FLD_BITS = 3 * REG_FLD_W + 2 * XLEN;
    localparam int S_TDATA_W  = ((S_FLD_BITS + 7) / 8) * 8;
    localparam int M_FLD_BITS = 4 * XLEN + 1 + REG_FLD_W + 2 + 2 + 2;
    localparam int M_TDATA_W  = ((M_FLD_BITS + 7) / 8) * 8;

    localparam logic [XLEN-1:0] PC_STEP    = 32'd4;
    localparam logic [XLEN-1:0] ALIGN_MASK = 32'hFFFF_FFFE;

    typedef enum logic [CMD_W-1:0] {
        CMD_LUI    = 6'd0,  CMD_AUIPC = 6'd1,  CMD_JAL   = 6'd2,  CMD_JALR  = 6'd3,
        CMD_BEQ    = 6'd4,  CMD_BNE   = 6'd5,  CMD_BLT   = 6'd6,  CMD_BGE   = 6'd7,
        CMD_BLTU   = 6'd8,  CMD_BGEU  = 6'd9,  CMD_LB    = 6'd10, CMD_LH    = 6'd11,
        CMD_LW     = 6'd12, CMD_LBU   = 6'd13, CMD_LHU   = 6'd14, CMD_SB    = 6'd15,
        CMD_SH     = 6'd16, CMD_SW    = 6'd17, CMD_ADDI  = 6'd18, CMD_SLTI  = 6'd19,
        CMD_SLTIU  = 6'd20, CMD_XORI  = 6'd21, CMD_ORI   = 6'd22, CMD_ANDI  = 6'd23,
        CMD_SLLI   = 6'd24, CMD_SRLI  = 6'd25, CMD_SRAI  = 6'd26, CMD_ADD   = 6'd27,
        CMD_SUB    = 6'd28, CMD_SLL   = 6'd29, CMD_SLT   = 6'd30, CMD_SLTU  = 6'd31,
        CMD_XOR    = 6'd32, CMD_SRL   = 6'd33, CMD_SRA   = 6'd34, CMD_OR    = 6'd35,
        CMD_AND    = 6'd36, CMD_FENCE = 6'd37, CMD_ECALL = 6'd38, CMD_EBREAK = 6'd39,
        CMD_LOAD_RET = 6'd40
    } cmd_e;

    typedef enum logic [2:0] {
        LK_NONE = 3'd0, LK_LB = 3'd1, LK_LH = 3'd2, LK_LW = 3'd3, LK_LBU = 3'd4, LK_LHU = 3'd5
    } load_kind_e;

    typedef enum logic [1:0] {
        MOP_NONE = 2'd0, MOP_READ = 2'd1, MOP_WRITE = 2'd2
    } mem_op_e;

    typedef enum logic [1:0] {
        MSZ_BYTE = 2'd0, MSZ_HALF = 2'd1, MSZ_WORD = 2'd2
    } mem_size_e;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0, ST_ECALL = 2'd1, ST_EBREAK = 2'd2, ST_IGNORED = 2'd3
    } status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ADDRESS = 1'd0, CFG_STACK_START = 1'd1
    } cfg_idx_e;

    // one result transaction
    typedef struct packed {
        logic [1:0]           status;
        logic [XLEN-1:0]      store_data;
        logic [1:0]           mem_size;
        logic [XLEN-1:0]      mem_addr;
        logic [1:0]           mem_op;
        logic [XLEN-1:0]      write_value;
        logic [REG_FLD_W-1:0] write_reg;
        logic                 write_enable;
        logic [XLEN-1:0]      next_pc;
    } ex_result_t;

    // architectural state changes caused by one instruction
    typedef struct packed {
        logic                 halt_set;
        logic                 pend_set;
        logic                 pend_clear;
        logic [REG_FLD_W-1:0] pend_reg;
        load_kind_e           pend_kind;
        logic                 rf_we;
    } ex_update_t;

endpackage

// ===== rtl/rve_regfile.sv =====
// ----------------------------------------------------------------------------
// rve_regfile: integer register file
// one write port, two registered read ports with same-edge write bypass;
// per-entry valid bits make unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module rve_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [rve_pkg::REG_FLD_W-1:0] rd_addr1,
    input  logic [rve_pkg::REG_FLD_W-1:0] rd_addr2,
    output logic [rve_pkg::XLEN-1:0]      rd_data1,
    output logic [rve_pkg::XLEN-1:0]      rd_data2,
    input  logic                          wr_en,
    input  logic [rve_pkg::REG_FLD_W-1:0] wr_addr,
    input  logic [rve_pkg::XLEN-1:0]      wr_data
);
    import rve_pkg::*;

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [XLEN-1:0]      raw1_reg, raw2_reg;
    logic                 zero1_reg, zero2_reg;
    logic                 byp1_reg, byp2_reg;
    logic [XLEN-1:0]      byp_data_reg;
    logic                 wr_ok, rd1_ok, rd2_ok;

    // x0 and indexes beyond the file never hold data
    assign wr_ok  = wr_en && (wr_addr != '0) && ({1'b0, wr_addr} < (REG_FLD_W + 1)'(REG_COUNT));
    assign rd1_ok = (rd_addr1 != '0) && ({1'b0, rd_addr1} < (REG_FLD_W + 1)'(REG_COUNT));
    assign rd2_ok = (rd_addr2 != '0) && ({1'b0, rd_addr2} < (REG_FLD_W + 1)'(REG_COUNT));

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr[REG_IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            raw1_reg     <= mem[rd_addr1[REG_IDX_W-1:0]];
            raw2_reg     <= mem[rd_addr2[REG_IDX_W-1:0]];
            zero1_reg    <= !rd1_ok || !valid_reg[rd_addr1[REG_IDX_W-1:0]];
            zero2_reg    <= !rd2_ok || !valid_reg[rd_addr2[REG_IDX_W-1:0]];
            byp1_reg     <= wr_ok && rd1_ok && (wr_addr == rd_addr1);
            byp2_reg     <= wr_ok && rd2_ok && (wr_addr == rd_addr2);
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_ok) begin
            valid_reg[wr_addr[REG_IDX_W-1:0]] <= 1'b1;
        end
    end

    assign rd_data1 = byp1_reg ? byp_data_reg : (zero1_reg ? '0 : raw1_reg);
    assign rd_data2 = byp2_reg ? byp_data_reg : (zero2_reg ? '0 : raw2_reg);

endmodule

// ===== rtl/rve_alu.sv =====
// ----------------------------------------------------------------------------
// rve_alu: single-pass execute logic
// computes next pc, register write, memory request and status for one
// instruction, plus the halt and pending-load updates
// ----------------------------------------------------------------------------
module rve_alu (
    input  rve_pkg::cmd_e                 cmd,
    input  logic [rve_pkg::REG_FLD_W-1:0] rd,
    input  logic [rve_pkg::XLEN-1:0]      op_a,
    input  logic [rve_pkg::XLEN-1:0]      op_b,
    input  logic [rve_pkg::XLEN-1:0]      imm,
    input  logic [rve_pkg::XLEN-1:0]      load_data,
    input  logic [rve_pkg::XLEN-1:0]      pc,
    input  logic                          halted,
    input  logic [rve_pkg::REG_FLD_W-1:0] pend_reg,
    input  rve_pkg::load_kind_e           pend_kind,
    output rve_pkg::ex_result_t           result,
    output rve_pkg::ex_update_t           update
);
    import rve_pkg::*;

    logic [XLEN-1:0]      pc_seq, pc_rel, addr_sum, y, wval;
    logic [4:0]           shamt;
    logic                 take, wr;
    logic [REG_FLD_W-1:0] wreg;

    assign pc_seq   = pc + PC_STEP;
    assign pc_rel   = pc + imm;
    assign addr_sum = op_a + imm;
    assign y        = (cmd <= CMD_SRAI) ? imm : op_b;
    assign shamt    = y[4:0];

    always_comb begin
        unique case (cmd) inside
            CMD_BEQ:  take = (op_a == op_b);
            CMD_BNE:  take = (op_a != op_b);
            CMD_BLT:  take = $signed(op_a) < $signed(op_b);
            CMD_BGE:  take = !($signed(op_a) < $signed(op_b));
            CMD_BLTU: take = (op_a < op_b);
            CMD_BGEU: take = (op_a >= op_b);
            default:  take = 1'b0;
        endcase
    end

    always_comb begin
        result            = '0;
        update            = '0;
        update.pend_kind  = LK_NONE;
        result.next_pc    = pc_seq;
        wr                = 1'b0;
        wreg              = rd;
        wval              = '0;
        if (halted) begin
            result.next_pc = pc;
            result.status  = ST_IGNORED;
        end else begin
            unique case (cmd) inside
                CMD_LUI: begin
                    wval = imm;
                    wr   = 1'b1;
                end
                CMD_AUIPC: begin
                    wval = pc_rel;
                    wr   = 1'b1;
                end
                CMD_JAL: begin
                    wval           = pc_seq;
                    wr             = 1'b1;
                    result.next_pc = pc_rel;
                end
                CMD_JALR: begin
                    wval           = pc_seq;
                    wr             = 1'b1;
                    result.next_pc = addr_sum & ALIGN_MASK;
                end
                [CMD_BEQ:CMD_BGEU]: begin
                    if (take) begin
                        result.next_pc = pc_rel;
                    end
                end
                [CMD_LB:CMD_LHU]: begin
                    result.mem_op   = MOP_READ;
                    result.mem_addr = addr_sum;
                    update.pend_set = 1'b1;
                    update.pend_reg = rd;
                    unique case (cmd) inside
                        CMD_LB: begin
                            result.mem_size  = MSZ_BYTE;
                            update.pend_kind = LK_LB;
                        end
                        CMD_LH: begin
                            result.mem_size  = MSZ_HALF;
                            update.pend_kind = LK_LH;
                        end
                        CMD_LW: begin
                            result.mem_size  = MSZ_WORD;
                            update.pend_kind = LK_LW;
                        end
                        CMD_LBU: begin
                            result.mem_size  = MSZ_BYTE;
                            update.pend_kind = LK_LBU;
                        end
                        default: begin
                            result.mem_size  = MSZ_HALF;
                            update.pend_kind = LK_LHU;
                        end
                    endcase
                end
                [CMD_SB:CMD_SW]: begin
                    result.mem_op   = MOP_WRITE;
                    result.mem_addr = addr_sum;
                    unique case (cmd) inside
                        CMD_SB: begin
                            result.mem_size   = MSZ_BYTE;
                            result.store_data = {24'd0, op_b[7:0]};
                        end
                        CMD_SH: begin
                            result.mem_size   = MSZ_HALF;
                            result.store_data = {16'd0, op_b[15:0]};
                        end
                        default: begin
                            result.mem_size   = MSZ_WORD;
                            result.store_data = op_b;
                        end
                    endcase
                end
                [CMD_ADDI:CMD_AND]: begin
                    wr = 1'b1;
                    unique case (cmd) inside
                        CMD_ADDI, CMD_ADD:   wval = op_a + y;
                        CMD_SUB:             wval = op_a - y;
                        CMD_SLTI, CMD_SLT:   wval = {31'd0, $signed(op_a) < $signed(y)};
                        CMD_SLTIU, CMD_SLTU: wval = {31'd0, op_a < y};
                        CMD_XORI, CMD_XOR:   wval = op_a ^ y;
                        CMD_ORI, CMD_OR:     wval = op_a | y;
                        CMD_ANDI, CMD_AND:   wval = op_a & y;
                        CMD_SLLI, CMD_SLL:   wval = op_a << shamt;
                        CMD_SRLI, CMD_SRL:   wval = op_a >> shamt;
                        default:             wval = XLEN'($signed(op_a) >>> shamt);
                    endcase
                end
                CMD_FENCE: begin
                end
                CMD_ECALL: begin
                    result.next_pc  = pc;
                    result.status   = ST_ECALL;
                    update.halt_set = 1'b1;
                end
                CMD_EBREAK: begin
                    result.next_pc  = pc;
                    result.status   = ST_EBREAK;
                    update.halt_set = 1'b1;
                end
                CMD_LOAD_RET: begin
                    result.next_pc    = pc;
                    update.pend_clear = 1'b1;
                    wreg              = pend_reg;
                    wr                = 1'b1;
                    unique case (pend_kind)
                        LK_LB:   wval = {{24{load_data[7]}}, load_data[7:0]};
                        LK_LH:   wval = {{16{load_data[15]}}, load_data[15:0]};
                        LK_LW:   wval = load_data;
                        LK_LBU:  wval = {24'd0, load_data[7:0]};
                        LK_LHU:  wval = {16'd0, load_data[15:0]};
                        default: wr   = 1'b0;
                    endcase
                end
                default: begin
                    result.next_pc = pc;
                end
            endcase
        end
        // x0 and out-of-range indexes drop the write
        if (wr && (wreg != '0) && ({1'b0, wreg} < (REG_FLD_W + 1)'(REG_COUNT))) begin
            result.write_enable = 1'b1;
            result.write_reg    = wreg;
            result.write_value  = wval;
            update.rf_we        = 1'b1;
        end
    end

endmodule

// ===== rtl/rv32i_execute_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_execute_unit: RV32I integer execute stage
// input to result transaction: input register, execute, result register;
//   throughput: one instruction per cycle unless m_tready stalls the output
// register file reads happen at acceptance and are bypassed from the write
//   retiring on the same edge, so dependent instructions run back to back
// reset (aresetn low, synchronous): pc 0, register file reads zero, no pending
//   load, not halted, both channels empty
// ----------------------------------------------------------------------------
module rv32i_execute_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // instruction channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dest_reg[4:0], src1_reg[9:5], src2_reg[14:10], immediate[46:15],
    // load_data[78:47], zero pad[79]
    input  logic [rve_pkg::S_TDATA_W-1:0] s_tdata,
    // command[5:0]
    input  logic [rve_pkg::CMD_W-1:0]     s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc[31:0], write_enable[32], write_reg[37:33], write_value[69:38],
    // mem_op[71:70], mem_addr[103:72], mem_size[105:104], store_data[137:106],
    // status[139:138], zero pad[143:140]
    output logic [rve_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rve_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rve_pkg::XLEN-1:0]      cfg_data
);
    import rve_pkg::*;

    // unpacked input fields
    logic [REG_FLD_W-1:0] s_dest, s_src1, s_src2;
    logic [XLEN-1:0]      s_imm, s_ldata;

    // input register stage
    logic                 in_valid_reg;
    cmd_e                 cmd_reg;
    logic [REG_FLD_W-1:0] rd_reg;
    logic [XLEN-1:0]      imm_reg, ldata_reg;

    // architectural state
    logic [XLEN-1:0]      pc_reg;
    logic                 halted_reg;
    logic [REG_FLD_W-1:0] pend_reg_reg;
    load_kind_e           pend_kind_reg;

    // result register
    logic                 out_valid_reg;
    ex_result_t           out_data_reg;

    // execute stage
    logic                 s_fire, ex_fire, cfg_fire, cfg_x2;
    logic [XLEN-1:0]      op_a, op_b;
    ex_result_t           ex_result;
    ex_update_t           ex_update;
    logic                 rf_we;
    logic [REG_FLD_W-1:0] rf_waddr;
    logic [XLEN-1:0]      rf_wdata;

    assign s_dest  = s_tdata[4:0];
    assign s_src1  = s_tdata[9:5];
    assign s_src2  = s_tdata[14:10];
    assign s_imm   = s_tdata[46:15];
    assign s_ldata = s_tdata[78:47];

    // an instruction executes when the result register is free or draining
    assign ex_fire   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || ex_fire;
    assign s_fire    = s_tvalid && s_tready;

    // configuration writes complete immediately
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_x2    = cfg_fire && (cfg_index == CFG_STACK_START);

    // single register file write port: retiring instruction or stack pointer setup
    assign rf_we    = (ex_fire && ex_update.rf_we) || cfg_x2;
    assign rf_waddr = cfg_x2 ? REG_FLD_W'(2) : ex_result.write_reg;
    assign rf_wdata = cfg_x2 ? cfg_data : ex_result.write_value;

    rve_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire),
        .rd_addr1 (s_src1),
        .rd_addr2 (s_src2),
        .rd_data1 (op_a),
        .rd_data2 (op_b),
        .wr_en    (rf_we),
        .wr_addr  (rf_waddr),
        .wr_data  (rf_wdata)
    );

    rve_alu u_alu (
        .cmd       (cmd_reg),
        .rd        (rd_reg),
        .op_a      (op_a),
        .op_b      (op_b),
        .imm       (imm_reg),
        .load_data (ldata_reg),
        .pc        (pc_reg),
        .halted    (halted_reg),
        .pend_reg  (pend_reg_reg),
        .pend_kind (pend_kind_reg),
        .result    (ex_result),
        .update    (ex_update)
    );

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= cmd_e'(s_tuser);
            rd_reg    <= s_dest;
            imm_reg   <= s_imm;
            ldata_reg <= s_ldata;
        end
    end

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (ex_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    // pc, halt flag and pending load tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            pend_reg_reg  <= '0;
            pend_kind_reg <= LK_NONE;
        end else begin
            if (ex_fire) begin
                pc_reg <= ex_result.next_pc;
                if (ex_update.halt_set) begin
                    halted_reg <= 1'b1;
                end
                if (ex_update.pend_set) begin
                    pend_reg_reg  <= ex_update.pend_reg;
                    pend_kind_reg <= ex_update.pend_kind;
                end else if (ex_update.pend_clear) begin
                    pend_kind_reg <= LK_NONE;
                end
            end
            // entry point write reloads the pc
            if (cfg_fire && (cfg_index == CFG_START_ADDRESS)) begin
                pc_reg <= cfg_data;
            end
        end
    end

    // result register; refills in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ex_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            out_data_reg <= ex_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

endmodule

// ===== rtl/rve_checker.sv =====
// ----------------------------------------------------------------------------
// rve_checker: port-level assertions for the rv32i execute unit
// watches handshakes and result fields over time; bound to the top level
// ----------------------------------------------------------------------------
module rve_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rve_pkg::M_TDATA_W-1:0] m_tdata
);
    import rve_pkg::*;

    ex_result_t res;

    assign res = ex_result_t'(m_tdata[M_FLD_BITS-1:0]);

    // reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no back pressure on the input while the output drains
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // x0 is never reported as written
    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.write_enable |-> res.write_reg != '0)
        else $error("write to x0 reported");

    // an ignored instruction has no side effects
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.status == ST_IGNORED) |-> !res.write_enable && (res.mem_op == MOP_NONE))
        else $error("side effect while halted");

endmodule

bind rv32i_execute_unit rve_checker u_rve_checker (.*);
